// ===== src/assert_macros.svh =====
// assert_macros.svh: concurrent assertion helpers for the memory and address unit.
// Depends on nothing; a module that uses these macros has clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== src/c6502mau_pkg.sv =====
// c6502mau_pkg: types, codes and constants of the 6502 memory and address unit.
// No dependencies; every module of the unit imports it.
package c6502mau_pkg;

    localparam int unsigned MEM_BYTES_DEF = 65536;

    // Operation codes
    localparam logic [1:0] FUNC_READ_BYTE  = 2'd0;
    localparam logic [1:0] FUNC_WRITE_BYTE = 2'd1;
    localparam logic [1:0] FUNC_READ_WORD  = 2'd2;
    localparam logic [1:0] FUNC_EFF_ADDR   = 2'd3;

    // Addressing mode codes
    localparam logic [3:0] MODE_IMP  = 4'd0;
    localparam logic [3:0] MODE_ACC  = 4'd1;
    localparam logic [3:0] MODE_IMM  = 4'd2;
    localparam logic [3:0] MODE_ZP   = 4'd3;
    localparam logic [3:0] MODE_ZPX  = 4'd4;
    localparam logic [3:0] MODE_ZPY  = 4'd5;
    localparam logic [3:0] MODE_REL  = 4'd6;
    localparam logic [3:0] MODE_ABS  = 4'd7;
    localparam logic [3:0] MODE_ABSX = 4'd8;
    localparam logic [3:0] MODE_ABSY = 4'd9;
    localparam logic [3:0] MODE_IND  = 4'd10;
    localparam logic [3:0] MODE_IZX  = 4'd11;
    localparam logic [3:0] MODE_IZY  = 4'd12;

    // Zero-page wrap mask
    localparam logic [15:0] ZP_MASK = 16'h00FF;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] address;
        logic [7:0]  write_byte;
        logic [3:0]  mode;
        logic [15:0] prog_counter;
        logic [7:0]  index_x;
        logic [7:0]  index_y;
    } mau_in_t;

    typedef struct packed {
        logic [15:0] result_value;
        logic [2:0]  bus_reads;
    } mau_out_t;

    typedef enum logic [1:0] {
        ALU_ADD16,
        ALU_ADDZP,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t     op;
        logic [15:0] a;
        logic [23:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [15:0] sum;
        logic        borrow;
    } alu_rsp_t;

    typedef struct packed {
        logic        we;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } mem_req_t;

endpackage

// ===== src/c6502mau_alu.sv =====
// c6502mau_alu: shared adder/subtractor of the address unit.
// Depends on c6502mau_pkg for the request and response types.
module c6502mau_alu
    import c6502mau_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [15:0] add_sum;
    logic [24:0] diff;

    always_comb
    begin
        add_sum    = req.a + req.b[15:0];
        diff       = {9'b0, req.a} - {1'b0, req.b};
        rsp.sum    = add_sum;
        rsp.borrow = 1'b0;
        unique case (req.op)
            ALU_ADD16: rsp.sum = add_sum;
            ALU_ADDZP: rsp.sum = add_sum & ZP_MASK;
            ALU_SUB:
            begin
                rsp.sum    = diff[15:0];
                rsp.borrow = diff[24];
            end
            default:   rsp.sum = add_sum;
        endcase
    end

endmodule

// ===== src/c6502mau_mem.sv =====
// c6502mau_mem: single-port byte memory with registered read and a clearing pass.
// Depends on c6502mau_pkg for the request type.
module c6502mau_mem
    import c6502mau_pkg::*;
#(
    parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  mem_req_t   req,
    output logic [7:0] rdata,
    output logic       clearing
);

    localparam int unsigned    AW   = $clog2(MEM_BYTES);
    localparam logic [AW-1:0]  LAST = AW'(MEM_BYTES - 1);

    logic [7:0]    mem [MEM_BYTES];
    logic [7:0]    rdata_reg;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          clearing_reg, clearing_next;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    // Sweep every entry to zero after reset, one per cycle.
    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == LAST)
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clearing_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clearing_reg <= clearing_next;
        end
    end

    assign wr_en   = clearing_reg | req.we;
    assign wr_addr = clearing_reg ? clr_cnt_reg : req.addr[AW-1:0];
    assign wr_data = clearing_reg ? 8'd0 : req.wdata;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[req.addr[AW-1:0]];
    end

    assign rdata    = rdata_reg;
    assign clearing = clearing_reg;

endmodule

// ===== src/c6502mau_seq.sv =====
// c6502mau_seq: sequencer that walks each operation through memory reads and ALU steps.
// Depends on c6502mau_pkg and assert_macros.svh.
`include "assert_macros.svh"

module c6502mau_seq
    import c6502mau_pkg::*;
#(
    parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  mau_in_t    cmd,
    input  logic [7:0] mem_rdata,
    input  alu_rsp_t   alu_rsp,
    output alu_req_t   alu_req,
    output mem_req_t   mem_req,
    output logic       idle,
    output logic       done,
    output mau_out_t   result
);

    localparam bit          MEM_POW2 = ((MEM_BYTES & (MEM_BYTES - 1)) == 0);
    localparam logic [23:0] RED_BASE = 24'(MEM_BYTES);
    localparam logic [2:0]  RED_TOP  = 3'd7;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REDUCE,
        S_ISSUE,
        S_DATA
    } state_t;

    typedef enum logic [2:0] {
        OP_RDB,
        OP_WRB,
        OP_RDW,
        OP_ZP,
        OP_ABS,
        OP_IND,
        OP_IZX,
        OP_IZY
    } op_t;

    state_t      state_reg, state_next, after_addr;
    op_t         op_reg, op_next;
    logic [1:0]  step_reg, step_next;
    logic [15:0] ptr_reg, ptr_next;
    logic [15:0] raw_reg, raw_next;
    logic [7:0]  lo_reg, lo_next;
    logic [7:0]  idx_reg, idx_next;
    logic [7:0]  wdata_reg, wdata_next;
    logic [2:0]  reads_reg, reads_next;
    logic [2:0]  red_cnt_reg, red_cnt_next;
    logic        done_reg, done_next;
    mau_out_t    result_reg, result_next;

    logic        addr_go;
    logic [15:0] addr_val;
    logic        fin;
    logic [15:0] fin_val;
    logic [2:0]  fin_reads;

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        step_next    = step_reg;
        ptr_next     = ptr_reg;
        raw_next     = raw_reg;
        lo_next      = lo_reg;
        idx_next     = idx_reg;
        wdata_next   = wdata_reg;
        reads_next   = reads_reg;
        red_cnt_next = red_cnt_reg;
        done_next    = 1'b0;
        result_next  = result_reg;

        after_addr = MEM_POW2 ? S_ISSUE : S_REDUCE;
        addr_go    = 1'b0;
        addr_val   = alu_rsp.sum;
        fin        = 1'b0;
        fin_val    = 16'd0;
        fin_reads  = reads_reg;

        alu_req.op = ALU_ADD16;
        alu_req.a  = ptr_reg;
        alu_req.b  = 24'd1;

        mem_req.we    = 1'b0;
        mem_req.addr  = raw_reg;
        mem_req.wdata = wdata_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // Operand pointer P = PC + 1.
                    alu_req.a  = cmd.prog_counter;
                    idx_next   = 8'd0;
                    wdata_next = cmd.write_byte;
                    step_next  = 2'd0;
                    case (cmd.func)
                        FUNC_READ_BYTE:
                        begin
                            op_next    = OP_RDB;
                            reads_next = 3'd1;
                            addr_go    = 1'b1;
                            addr_val   = cmd.address;
                        end
                        FUNC_WRITE_BYTE:
                        begin
                            op_next    = OP_WRB;
                            reads_next = 3'd1;
                            addr_go    = 1'b1;
                            addr_val   = cmd.address;
                        end
                        FUNC_READ_WORD:
                        begin
                            op_next    = OP_RDW;
                            reads_next = 3'd2;
                            addr_go    = 1'b1;
                            addr_val   = cmd.address;
                        end
                        default:
                        begin
                            case (cmd.mode) inside
                                MODE_IMM, MODE_REL:
                                begin
                                    fin       = 1'b1;
                                    fin_val   = alu_rsp.sum;
                                    fin_reads = 3'd0;
                                end
                                MODE_ZP, MODE_ZPX, MODE_ZPY:
                                begin
                                    op_next    = OP_ZP;
                                    reads_next = 3'd1;
                                    addr_go    = 1'b1;
                                    if (cmd.mode == MODE_ZPX)
                                    begin
                                        idx_next = cmd.index_x;
                                    end
                                    else if (cmd.mode == MODE_ZPY)
                                    begin
                                        idx_next = cmd.index_y;
                                    end
                                end
                                MODE_ABS, MODE_ABSX, MODE_ABSY:
                                begin
                                    op_next    = OP_ABS;
                                    reads_next = 3'd2;
                                    addr_go    = 1'b1;
                                    if (cmd.mode == MODE_ABSX)
                                    begin
                                        idx_next = cmd.index_x;
                                    end
                                    else if (cmd.mode == MODE_ABSY)
                                    begin
                                        idx_next = cmd.index_y;
                                    end
                                end
                                MODE_IND:
                                begin
                                    op_next    = OP_IND;
                                    reads_next = 3'd2;
                                    addr_go    = 1'b1;
                                end
                                MODE_IZX:
                                begin
                                    op_next    = OP_IZX;
                                    reads_next = 3'd3;
                                    idx_next   = cmd.index_x;
                                    addr_go    = 1'b1;
                                end
                                MODE_IZY:
                                begin
                                    op_next    = OP_IZY;
                                    reads_next = 3'd3;
                                    idx_next   = cmd.index_y;
                                    addr_go    = 1'b1;
                                end
                                default:
                                begin
                                    // implied, accumulator and unused codes
                                    fin       = 1'b1;
                                    fin_val   = 16'd0;
                                    fin_reads = 3'd0;
                                end
                            endcase
                        end
                    endcase
                end
            end

            S_REDUCE:
            begin
                // Restoring reduction of the address modulo the memory size.
                alu_req.op = ALU_SUB;
                alu_req.a  = raw_reg;
                alu_req.b  = RED_BASE << red_cnt_reg;
                if (!alu_rsp.borrow)
                begin
                    raw_next = alu_rsp.sum;
                end
                if (red_cnt_reg == 3'd0)
                begin
                    state_next = S_ISSUE;
                end
                else
                begin
                    red_cnt_next = red_cnt_reg - 3'd1;
                end
            end

            S_ISSUE:
            begin
                if (op_reg == OP_WRB)
                begin
                    mem_req.we = 1'b1;
                    fin        = 1'b1;
                    fin_val    = 16'd0;
                end
                else
                begin
                    state_next = S_DATA;
                end
            end

            S_DATA:
            begin
                unique case (op_reg)
                    OP_RDB:
                    begin
                        fin     = 1'b1;
                        fin_val = {8'd0, mem_rdata};
                    end
                    OP_ZP:
                    begin
                        alu_req.op = ALU_ADDZP;
                        alu_req.a  = {8'd0, mem_rdata};
                        alu_req.b  = {16'd0, idx_reg};
                        fin        = 1'b1;
                        fin_val    = alu_rsp.sum;
                    end
                    OP_RDW, OP_ABS:
                    begin
                        if (step_reg == 2'd0)
                        begin
                            lo_next = mem_rdata;
                            addr_go = 1'b1;
                        end
                        else
                        begin
                            alu_req.a = {mem_rdata, lo_reg};
                            alu_req.b = {16'd0, idx_reg};
                            fin       = 1'b1;
                            fin_val   = alu_rsp.sum;
                        end
                    end
                    OP_IND:
                    begin
                        case (step_reg)
                            2'd0, 2'd2:
                            begin
                                lo_next = mem_rdata;
                                addr_go = 1'b1;
                            end
                            2'd1:
                            begin
                                addr_go  = 1'b1;
                                addr_val = {mem_rdata, lo_reg};
                            end
                            default:
                            begin
                                fin     = 1'b1;
                                fin_val = {mem_rdata, lo_reg};
                            end
                        endcase
                    end
                    OP_IZX, OP_IZY:
                    begin
                        case (step_reg)
                            2'd0:
                            begin
                                addr_go = 1'b1;
                                if (op_reg == OP_IZX)
                                begin
                                    alu_req.op = ALU_ADDZP;
                                    alu_req.a  = {8'd0, mem_rdata};
                                    alu_req.b  = {16'd0, idx_reg};
                                end
                                else
                                begin
                                    addr_val = {8'd0, mem_rdata};
                                end
                            end
                            2'd1:
                            begin
                                // high byte of the pointer stays in zero page
                                alu_req.op = ALU_ADDZP;
                                lo_next    = mem_rdata;
                                addr_go    = 1'b1;
                            end
                            default:
                            begin
                                alu_req.a = {mem_rdata, lo_reg};
                                alu_req.b = (op_reg == OP_IZY) ? {16'd0, idx_reg} : 24'd0;
                                fin       = 1'b1;
                                fin_val   = alu_rsp.sum;
                            end
                        endcase
                    end
                    default:
                    begin
                        fin     = 1'b1;
                        fin_val = 16'd0;
                    end
                endcase
                if (addr_go)
                begin
                    step_next = step_reg + 2'd1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (addr_go)
        begin
            ptr_next     = addr_val;
            raw_next     = addr_val;
            red_cnt_next = RED_TOP;
            state_next   = after_addr;
        end
        if (fin)
        begin
            done_next   = 1'b1;
            result_next = '{result_value: fin_val, bus_reads: fin_reads};
            state_next  = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            op_reg      <= OP_RDB;
            step_reg    <= 2'd0;
            ptr_reg     <= 16'd0;
            raw_reg     <= 16'd0;
            lo_reg      <= 8'd0;
            idx_reg     <= 8'd0;
            wdata_reg   <= 8'd0;
            reads_reg   <= 3'd0;
            red_cnt_reg <= 3'd0;
            done_reg    <= 1'b0;
            result_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            step_reg    <= step_next;
            ptr_reg     <= ptr_next;
            raw_reg     <= raw_next;
            lo_reg      <= lo_next;
            idx_reg     <= idx_next;
            wdata_reg   <= wdata_next;
            reads_reg   <= reads_next;
            red_cnt_reg <= red_cnt_next;
            done_reg    <= done_next;
            result_reg  <= result_next;
        end
    end

    assign idle   = (state_reg == S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    `ASSERT_CLK(a_addr_reduced, (state_reg == S_ISSUE) |-> (MEM_POW2 || ({16'd0, raw_reg} < MEM_BYTES)), "memory address not reduced below memory size")
    `ASSERT_NEVER(a_step_bound, (state_reg == S_DATA) && (op_reg != OP_IND) && (step_reg == 2'd3), "read step past the end of the operation")
    `ASSERT_CLK(a_write_result, (state_reg == S_ISSUE && op_reg == OP_WRB) |=> (done_reg && result_reg.result_value == 16'd0), "write did not finish with a zero result")

endmodule

// ===== src/cpu6502_memory_and_address_unit.sv =====
// cpu6502_memory_and_address_unit: top level of the 6502 memory and address unit.
// Depends on c6502mau_pkg, c6502mau_alu, c6502mau_mem, c6502mau_seq and assert_macros.svh.
`include "assert_macros.svh"

// A byte memory of MEM_BYTES entries with a 6502 effective-address unit. A command
// transfers at a rising edge where start is high and busy is low; its result
// appears on result for exactly one cycle with done high and must be taken then,
// since the unit cannot be held off. After reset the unit sweeps the memory to zero,
// one byte per cycle, and holds busy high until the sweep ends. Every memory access
// goes through one single-port memory with a registered read: each read access has
// an address issue state and a data return state, and a write finishes at issue.
// busy stays high while memory accesses run, counted or not: the indirect mode
// makes four accesses, (zp,x) and (zp),y three, a word read and the absolute modes
// two, a byte read, the zero-page modes and a write one, and immediate, relative and
// implied commands none, so they never raise busy. done rises at the same edge at
// which busy falls, so the next command can transfer in the cycle that carries the
// previous result; a command that never raises busy has its result in the cycle
// after its transfer. When MEM_BYTES is not a power of two every address is first
// reduced modulo MEM_BYTES in the shared adder, one quotient bit per cycle.
module cpu6502_memory_and_address_unit
    import c6502mau_pkg::*;
#(
    parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  mau_in_t  request,
    output logic     done,
    output mau_out_t result
);

    alu_req_t   alu_req;
    alu_rsp_t   alu_rsp;
    mem_req_t   mem_req;
    logic [7:0] mem_rdata;
    logic       clearing;
    logic       seq_idle;
    logic       accept;

    // Hold off commands while the clear sweep runs or an operation is in flight.
    assign busy   = clearing | ~seq_idle;
    assign accept = start & ~busy;

    c6502mau_seq #(
        .MEM_BYTES (MEM_BYTES)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cmd       (request),
        .mem_rdata (mem_rdata),
        .alu_rsp   (alu_rsp),
        .alu_req   (alu_req),
        .mem_req   (mem_req),
        .idle      (seq_idle),
        .done      (done),
        .result    (result)
    );

    // One adder serves pointer increments, index adds and address reduction.
    c6502mau_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    c6502mau_mem #(
        .MEM_BYTES (MEM_BYTES)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (mem_req),
        .rdata    (mem_rdata),
        .clearing (clearing)
    );

    `ASSERT_NEVER(a_no_write_while_clearing, clearing && mem_req.we, "memory write during the clear sweep")
    `ASSERT_CLK(a_done_frees_unit, done |-> !busy, "unit still busy when a result transfers")

endmodule
